// File: hdl/mrfb_pkg.sv
// Package for the Modbus RTU request frame builder.
// Holds transaction structs, frame constants and function codes.
// No dependencies.
package mrfb_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned BODY_LEN  = 6;
    localparam int unsigned IDX_W     = 3;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(BODY_LEN);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Command encodings and Modbus function codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

    // Request transaction
    typedef struct packed {
        logic        command;
        logic [7:0]  slave_address;
        logic [15:0] start_register;
        logic [15:0] operand_value;
    } req_t;

    // Frame byte transaction
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_t;

    // Six frame body bytes, entry 0 is sent first
    typedef logic [BODY_LEN-1:0][7:0] body_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

// File: hdl/mrfb_front.sv
// Front end: classifies a request and lays out the six frame body bytes.
// Depends on mrfb_pkg.
module mrfb_front
    import mrfb_pkg::*;
(
    input  req_t  req,
    output body_t body
);

    logic [7:0] func_code;

    // Map command to function code
    always_comb
    begin
        case (req.command)
            CMD_WRITE: func_code = FUNC_WRITE_SINGLE;
            CMD_READ:  func_code = FUNC_READ_HOLDING;
            default:   func_code = FUNC_READ_HOLDING;
        endcase
    end

    // Lay out body bytes in transmit order
    always_comb
    begin
        body[0] = req.slave_address;
        body[1] = func_code;
        body[2] = req.start_register[15:8];
        body[3] = req.start_register[7:0];
        body[4] = req.operand_value[15:8];
        body[5] = req.operand_value[7:0];
    end

endmodule

// File: hdl/mrfb_fifo.sv
// Short register queue of frame bodies between front and back ends.
// Depends on mrfb_pkg.
module mrfb_fifo
    import mrfb_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  body_t     push_data,
    input  logic      pop,
    output body_t     head,
    output q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    body_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.avail = (count_reg != '0);
    assign head         = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed body
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.avail)
        else $error("pop from empty queue");

endmodule

// File: hdl/mrfb_back.sv
// Back end: serializes a frame body, accumulates CRC-16/MODBUS, appends it.
// Depends on mrfb_pkg; drives the registered frame output.
module mrfb_back
    import mrfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  body_t     head,
    input  q_status_t status,
    output logic      pop,
    output logic      frame_valid,
    input  logic      frame_stall,
    output frame_t    frame
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    frame_t           out_data_reg, out_data_next;
    logic             load_ok;
    logic             advance;
    logic [7:0]       body_byte;
    logic             in_body;

    // One byte through the reflected CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign load_ok = !out_valid_reg || !frame_stall;
    assign advance = status.avail && load_ok;
    assign pop     = advance && (idx_reg == LAST_IDX);
    assign in_body = (idx_reg < CRC_LO_IDX);

    // Pick the body byte for the current position
    always_comb
    begin
        body_byte = '0;
        if (in_body)
        begin
            body_byte = head[idx_reg];
        end
    end

    // Select next output byte and CRC
    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_ok)
        begin
            out_valid_next = advance;
        end
        if (advance)
        begin
            out_data_next.last_byte = (idx_reg == LAST_IDX);
            if (in_body)
            begin
                out_data_next.frame_byte = body_byte;
                crc_next = crc_byte(crc_reg, body_byte);
            end
            else if (idx_reg == CRC_LO_IDX)
            begin
                out_data_next.frame_byte = crc_reg[7:0];
            end
            else
            begin
                out_data_next.frame_byte = crc_reg[15:8];
            end
            // Wrap to the next frame after the CRC high byte
            if (idx_reg == LAST_IDX)
            begin
                idx_next = '0;
                crc_next = CRC_INIT;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_data_reg;

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg == LAST_IDX) |=> (idx_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame position or CRC not reset after last byte");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg != LAST_IDX) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("frame position did not advance by one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(idx_reg) && $stable(crc_reg)))
        else $error("frame state moved without an emitted byte");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (frame_valid && (frame.last_byte == ($past(idx_reg) == LAST_IDX))))
        else $error("last byte flagged at wrong frame position");

endmodule

// File: hdl/modbus_request_frame_builder_top.sv
// Top level of the Modbus RTU request frame builder.
// Depends on mrfb_pkg, mrfb_front, mrfb_fifo and mrfb_back.
//
//  Channel  Signals                          Moves
//  -------  -------------------------------  ---------------------------------
//  req      req_valid, req_stall, req        one request (command, address,
//                                            register, operand)
//  frame    frame_valid, frame_stall, frame  one frame byte plus last flag
//
// Each request yields eight frame bytes, one per cycle from the serializer while
// frame_stall is low; the byte serializer sets the sustained request rate.
// An accepted request is queued first; its first byte is then registered.
// Requests are taken while the body queue (QUEUE_DEPTH entries) has room, so
// new requests enter while a frame is still streaming out.
// Reset is asynchronous, active low; it empties the queue and output register.
// A stall on frame holds the current byte and backs up into the queue only.
module modbus_request_frame_builder_top
    import mrfb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    input  req_t   req,
    output logic   frame_valid,
    input  logic   frame_stall,
    output frame_t frame
);

    body_t     body;
    body_t     head;
    q_status_t status;
    logic      push;
    logic      pop;

    assign req_stall = status.full;
    assign push      = req_valid && !status.full;

    mrfb_front u_front (
        .req  (req),
        .body (body)
    );

    mrfb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (body),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    mrfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

endmodule
